// File: src/crfd_pkg.sv
package crfd_pkg;

  // Item operation codes.
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POLL  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Control byte fields.
  localparam int CTRL_IDE_BIT = 4;
  localparam int CTRL_RTR_BIT = 5;
  localparam int CTRL_FDF_BIT = 7;
  localparam logic [3:0] MAX_DLC = 4'd8;

  localparam int FILL_W = 7;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // Raw record as held in the ring storage.
  typedef struct packed {
    logic [63:0] payload;
    logic [7:0]  ctrl;
    logic [31:0] id_word;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
    logic deliver;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: src/crfd_ctrl.sv
module crfd_ctrl
  import crfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        // Wait until the output register can take the result.
        if (sts.out_free) begin
          cmd.deliver = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/crfd_datapath.sv
module crfd_datapath
  import crfd_pkg::*;
#(
  parameter int RING_DEPTH    = 64,
  parameter int CHANNEL_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_channel,
  input  logic [2:0]  in_error_flags,
  input  logic        in_record_present,
  input  logic [31:0] in_raw_id_word,
  input  logic [7:0]  in_raw_ctrl_byte,
  input  logic [63:0] in_raw_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_valid,
  output logic [1:0]  out_frame_channel,
  output logic [31:0] out_frame_id,
  output logic [3:0]  out_frame_len,
  output logic [63:0] out_frame_data,
  output logic        out_entry_consumed,
  output logic        out_record_dropped,
  output logic [2:0]  out_failure_bits,
  output logic [6:0]  out_fill_level
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int SLOTS  = CHANNEL_COUNT * RING_DEPTH;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  typedef struct packed {
    logic              consumed;
    logic              dropped;
    logic [2:0]        failures;
    logic [FILL_W-1:0] fill;
  } stat_t;

  // Captured item.
  logic [1:0]  mode_r;
  logic [1:0]  channel_r;
  logic [2:0]  errs_r;
  logic        present_r;
  rec_t        rec_in_r;

  // Per-channel ring state.
  logic [IDX_W-1:0] rdidx_r  [CHANNEL_COUNT];
  logic [CNT_W-1:0] count_r  [CHANNEL_COUNT];
  logic [2:0]       sticky_r [CHANNEL_COUNT];

  rec_t  mem_r [SLOTS];
  rec_t  rd_rec_r;
  stat_t stat_r;
  stat_t stat_nxt;

  logic              out_valid_r;
  logic              frame_valid_r;
  logic [31:0]       frame_id_r;
  logic [3:0]        frame_len_r;
  logic [63:0]       frame_data_r;
  stat_t             out_stat_r;
  logic [1:0]        out_channel_r;

  logic              ch_ok;
  logic [CH_W-1:0]   ch_idx;
  logic [IDX_W-1:0]  rd_cur;
  logic [CNT_W-1:0]  count_cur;
  logic              ring_full;
  logic              push_do;
  logic              pop_do;
  logic [SUM_W-1:0]  wr_sum;
  logic [IDX_W-1:0]  wr_slot;
  logic [ADDR_W-1:0] ch_base;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [IDX_W-1:0]  rdidx_nxt;
  logic [CNT_W-1:0]  count_nxt;
  logic [2:0]        sticky_nxt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r           <= in_mode;
      channel_r        <= in_channel;
      errs_r           <= in_error_flags;
      present_r        <= in_record_present;
      rec_in_r.id_word <= in_raw_id_word;
      rec_in_r.ctrl    <= in_raw_ctrl_byte;
      rec_in_r.payload <= in_raw_payload;
    end
  end

  assign ch_ok     = 32'(channel_r) < CHANNEL_COUNT;
  assign ch_idx    = CH_W'(channel_r);
  assign rd_cur    = rdidx_r[ch_idx];
  assign count_cur = count_r[ch_idx];
  assign ring_full = count_cur == CNT_W'(RING_DEPTH);
  assign push_do   = ch_ok && (mode_r == MODE_PUSH) && present_r && !ring_full;
  assign pop_do    = ch_ok && (mode_r == MODE_POLL) && (count_cur != '0);

  assign wr_sum  = SUM_W'(rd_cur) + SUM_W'(count_cur);
  assign wr_slot = (wr_sum >= SUM_W'(RING_DEPTH)) ? IDX_W'(wr_sum - SUM_W'(RING_DEPTH))
                                                  : IDX_W'(wr_sum);
  assign ch_base = ADDR_W'(int'(ch_idx) * RING_DEPTH);
  assign wr_addr = ch_base + ADDR_W'(wr_slot);
  assign rd_addr = ch_base + ADDR_W'(rd_cur);

  always_comb begin
    rdidx_nxt  = rd_cur;
    count_nxt  = count_cur;
    sticky_nxt = sticky_r[ch_idx];
    if (push_do) begin
      count_nxt = count_cur + CNT_W'(1);
    end
    if (pop_do) begin
      count_nxt = count_cur - CNT_W'(1);
      rdidx_nxt = (rd_cur == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_cur + IDX_W'(1);
    end
    case (mode_r)
      MODE_PUSH:  sticky_nxt = sticky_r[ch_idx] | errs_r;
      MODE_CLEAR: sticky_nxt = '0;
      default:    sticky_nxt = sticky_r[ch_idx];
    endcase

    stat_nxt = '0;
    if (ch_ok) begin
      stat_nxt.consumed = pop_do;
      stat_nxt.dropped  = (mode_r == MODE_PUSH) && present_r && ring_full;
      stat_nxt.failures = sticky_nxt;
      stat_nxt.fill     = FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        rdidx_r[i]  <= '0;
        count_r[i]  <= '0;
        sticky_r[i] <= '0;
      end
    end else if (cmd.execute && ch_ok) begin
      rdidx_r[ch_idx]  <= rdidx_nxt;
      count_r[ch_idx]  <= count_nxt;
      sticky_r[ch_idx] <= sticky_nxt;
    end
  end

  // Ring storage: one write or one registered read per item.
  always_ff @(posedge clk) begin
    if (cmd.execute && push_do) begin
      mem_r[wr_addr] <= rec_in_r;
    end
    if (cmd.execute && pop_do) begin
      rd_rec_r <= mem_r[rd_addr];
    end
    if (cmd.execute) begin
      stat_r <= stat_nxt;
    end
  end

  // Decode of the popped record.
  logic        dec_valid;
  logic [31:0] dec_id;
  logic [3:0]  dec_dlc;
  logic [63:0] dec_data;

  always_comb begin
    dec_dlc   = rd_rec_r.ctrl[3:0];
    dec_valid = stat_r.consumed && (dec_dlc <= MAX_DLC) &&
                !(rd_rec_r.ctrl[CTRL_RTR_BIT] && !rd_rec_r.ctrl[CTRL_FDF_BIT]);
    if (rd_rec_r.ctrl[CTRL_IDE_BIT]) begin
      dec_id = {1'b1, 2'b00, rd_rec_r.id_word[10:0], rd_rec_r.id_word[28:11]};
    end else begin
      dec_id = {21'd0, rd_rec_r.id_word[10:0]};
    end
    for (int k = 0; k < 8; k++) begin
      dec_data[8*k +: 8] = (4'(k) < dec_dlc) ? rd_rec_r.payload[8*k +: 8] : 8'd0;
    end
    if (!dec_valid) begin
      dec_id   = '0;
      dec_dlc  = '0;
      dec_data = '0;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      frame_valid_r <= dec_valid;
      frame_id_r    <= dec_id;
      frame_len_r   <= dec_dlc;
      frame_data_r  <= dec_data;
      out_stat_r    <= stat_r;
      out_channel_r <= channel_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_valid    = frame_valid_r;
  assign out_frame_channel  = out_channel_r;
  assign out_frame_id       = frame_id_r;
  assign out_frame_len      = frame_len_r;
  assign out_frame_data     = frame_data_r;
  assign out_entry_consumed = out_stat_r.consumed;
  assign out_record_dropped = out_stat_r.dropped;
  assign out_failure_bits   = out_stat_r.failures;
  assign out_fill_level     = out_stat_r.fill;

endmodule

// File: src/can_rx_ring_frame_decoder_top.sv
// CAN receive ring with frame decoding, one ring of raw records per channel.
// Input channel (in_*): each beat is a push event (error flags plus an
// optional raw record), a poll that pops and decodes the oldest record, or a
// clear of the channel's sticky failure flags. A beat is taken at a clock edge
// where in_valid is high and in_stall is low.
// Result channel (out_*): exactly one result beat per input beat, in order,
// taken where out_valid is high and out_stall is low.
// Sequence: an accepted item is captured into registers, then executed
// (ring write, or ring read into a register), and its result is loaded into
// the output register once that register is free, so it is visible from then
// on. The block handles one item at a time and takes the next beat only after
// the result has been loaded.
// Reset: all rings are empty, read pointers are zero and the failure flags are
// clear; the ring storage itself is not cleared, since only written slots are
// ever read, so no clearing pass is needed.
// Stall: a result that is not taken stays in the output register unchanged;
// the block then holds its finished item and keeps in_stall high.
module can_rx_ring_frame_decoder_top
  import crfd_pkg::*;
#(
  parameter int RING_DEPTH    = 64,
  parameter int CHANNEL_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_channel,
  input  logic [2:0]  in_error_flags,
  input  logic        in_record_present,
  input  logic [31:0] in_raw_id_word,
  input  logic [7:0]  in_raw_ctrl_byte,
  input  logic [63:0] in_raw_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_valid,
  output logic [1:0]  out_frame_channel,
  output logic [31:0] out_frame_id,
  output logic [3:0]  out_frame_len,
  output logic [63:0] out_frame_data,
  output logic        out_entry_consumed,
  output logic        out_record_dropped,
  output logic [2:0]  out_failure_bits,
  output logic [6:0]  out_fill_level
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences capture, execute and deliver for each item.
  crfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the rings, per-channel pointers and the output register.
  crfd_datapath #(
    .RING_DEPTH    (RING_DEPTH),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_mode),
    .in_channel         (in_channel),
    .in_error_flags     (in_error_flags),
    .in_record_present  (in_record_present),
    .in_raw_id_word     (in_raw_id_word),
    .in_raw_ctrl_byte   (in_raw_ctrl_byte),
    .in_raw_payload     (in_raw_payload),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_valid    (out_frame_valid),
    .out_frame_channel  (out_frame_channel),
    .out_frame_id       (out_frame_id),
    .out_frame_len      (out_frame_len),
    .out_frame_data     (out_frame_data),
    .out_entry_consumed (out_entry_consumed),
    .out_record_dropped (out_record_dropped),
    .out_failure_bits   (out_failure_bits),
    .out_fill_level     (out_fill_level)
  );

  // One item at a time: an accepted beat closes the input side next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in flight");

  // A delivered frame always comes from an entry that the poll removed.
  a_frame_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_valid |-> out_entry_consumed)
    else $error("frame delivered without consuming an entry");

  // A result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deliver |-> !out_valid || !out_stall)
    else $error("pending result overwritten");

  // A poll and a dropped push cannot both be reported by one result.
  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_dropped |-> !out_entry_consumed)
    else $error("result reports both a drop and a consumed entry");

endmodule
